>>> rtl/pad_hit_position_to_id_macros.svh
// Assertion helpers used by the top-level design file. Each macro expects signals
// named clk and rst in the module that uses it.
`ifndef PAD_HIT_POSITION_TO_ID_MACROS_SVH
`define PAD_HIT_POSITION_TO_ID_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PHID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PHID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/phid_pkg.sv
package phid_pkg;

  localparam int POS_W = 24;
  localparam int HEIGHT_W = 23;
  localparam int COUNT_W = 7;
  localparam int LINE_CNT_W = 2;
  localparam int LINE_W = 64;
  localparam int ROW_W = 6;
  localparam int COL_W = 2;
  localparam int PAD_W = 9;
  localparam int CFG_IDX_W = 3;

  // Default number of boundary lines built into the block.
  localparam int MAX_COLUMN_LINES_DEF = 3;

  // Number of rows the board may have at most.
  localparam logic [COUNT_W-1:0] ROWS_LIMIT = 7'd64;

  // Register stages from the input register to the row and column results.
  localparam int ROW_LAT = 10;
  localparam int COL_LAT = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FIRST_END = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LAST_BEGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LINE_BASE = 3'd5;

  // Row geometry handed to the row unit.
  typedef struct packed {
    logic signed [POS_W-1:0] first_end;
    logic signed [POS_W-1:0] last_begin;
    logic [HEIGHT_W-1:0]     height;
    logic [COUNT_W-1:0]      count;
  } row_cfg_t;

endpackage

>>> rtl/phid_row_unit.sv
// Row lookup: classifies y against the first and last rows and divides the
// offset into the inner rows by the row height, one quotient bit per stage.
module phid_row_unit (
  input  logic                            clk,
  input  logic signed [phid_pkg::POS_W-1:0] y,
  input  phid_pkg::row_cfg_t              cfg,
  output logic [phid_pkg::ROW_W-1:0]      row
);

  localparam int NUM_W = phid_pkg::POS_W + 1;
  localparam int DIV_STEPS = phid_pkg::ROW_W;
  localparam int CMP_W = phid_pkg::HEIGHT_W + DIV_STEPS;

  typedef struct packed {
    logic                          below;
    logic                          above;
    logic                          sat;
    logic [NUM_W-1:0]              rem;
    logic [phid_pkg::ROW_W-1:0]    quo;
  } div_stage_t;

  logic [phid_pkg::HEIGHT_W-1:0] h_eff;
  logic [phid_pkg::COUNT_W-1:0]  rc_eff;
  logic [phid_pkg::ROW_W-1:0]    last_row;
  logic signed [NUM_W-1:0]       diff_full;

  logic                          below1;
  logic                          above1;
  logic [phid_pkg::POS_W-1:0]    diff1;
  logic                          below2;
  logic                          above2;
  logic [NUM_W-1:0]              num2;
  div_stage_t                    div [0:DIV_STEPS];
  logic [CMP_W-1:0]              h_sh [1:DIV_STEPS];
  logic [DIV_STEPS:1]            take;
  logic [phid_pkg::ROW_W-1:0]    row_next;

  always_comb begin
    h_eff = (cfg.height == '0) ? phid_pkg::HEIGHT_W'(1) : cfg.height;
    if (cfg.count == '0) begin
      rc_eff = phid_pkg::COUNT_W'(1);
    end else if (cfg.count > phid_pkg::ROWS_LIMIT) begin
      rc_eff = phid_pkg::ROWS_LIMIT;
    end else begin
      rc_eff = cfg.count;
    end
    last_row = phid_pkg::ROW_W'(rc_eff - phid_pkg::COUNT_W'(1));
    diff_full = {y[phid_pkg::POS_W-1], y} -
                {cfg.first_end[phid_pkg::POS_W-1], cfg.first_end};
  end

  // Stage 1: where y lies relative to the first and last rows. When y is
  // above the first row end, the offset is positive and fits in 24 bits.
  always_ff @(posedge clk) begin
    below1 <= (y <= cfg.first_end);
    above1 <= (y > cfg.last_begin);
    diff1  <= diff_full[phid_pkg::POS_W-1:0];
  end

  // Stage 2: bias the numerator so that the floor division gives the ceiling.
  always_ff @(posedge clk) begin
    below2 <= below1;
    above2 <= above1;
    num2   <= NUM_W'(diff1) + NUM_W'(h_eff) - NUM_W'(1);
  end

  // Trial subtraction for each division step.
  always_comb begin
    for (int j = 1; j <= DIV_STEPS; j++) begin
      h_sh[j] = CMP_W'(h_eff) << (DIV_STEPS - j);
      take[j] = (CMP_W'(div[j-1].rem) >= h_sh[j]);
    end
  end

  // Stage 3: a quotient of 64 or more saturates at the last row anyway.
  // Every later stage is one restoring division step, most significant
  // quotient bit first.
  always_ff @(posedge clk) begin
    div[0].below <= below2;
    div[0].above <= above2;
    div[0].sat   <= (CMP_W'(num2) >= (CMP_W'(h_eff) << DIV_STEPS));
    div[0].rem   <= num2;
    div[0].quo   <= '0;
    for (int j = 1; j <= DIV_STEPS; j++) begin
      div[j].below <= div[j-1].below;
      div[j].above <= div[j-1].above;
      div[j].sat   <= div[j-1].sat;
      div[j].rem   <= take[j] ? (div[j-1].rem - h_sh[j][NUM_W-1:0]) : div[j-1].rem;
      div[j].quo   <= div[j-1].quo | (phid_pkg::ROW_W'(take[j]) << (DIV_STEPS - j));
    end
  end

  always_comb begin
    if (div[DIV_STEPS].below) begin
      row_next = '0;
    end else if (div[DIV_STEPS].above || div[DIV_STEPS].sat) begin
      row_next = last_row;
    end else if (div[DIV_STEPS].quo > last_row) begin
      row_next = last_row;
    end else begin
      row_next = div[DIV_STEPS].quo;
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
  end

endmodule

>>> rtl/phid_col_unit.sv
// Column lookup: one lane per boundary line computes slope * y against
// (x - intercept) * 65536 exactly, then the first line right of the hit wins.
module phid_col_unit #(
  parameter int MAX_COLUMN_LINES = phid_pkg::MAX_COLUMN_LINES_DEF
) (
  input  logic                                          clk,
  input  logic signed [phid_pkg::POS_W-1:0]             x,
  input  logic signed [phid_pkg::POS_W-1:0]             y,
  input  logic [MAX_COLUMN_LINES-1:0][phid_pkg::LINE_W-1:0] lines,
  input  logic [phid_pkg::LINE_CNT_W-1:0]               lines_eff,
  output logic [phid_pkg::COL_W-1:0]                    col
);

  localparam int HALF_W = phid_pkg::LINE_W / 2;
  localparam int PROD_W = HALF_W + phid_pkg::POS_W;
  localparam int XD_W = HALF_W + 1;
  localparam int FRAC_W = 16;
  localparam int CMP_W = PROD_W + 1;

  logic [MAX_COLUMN_LINES-1:0] right;
  logic [phid_pkg::COL_W-1:0]  col_next;

  for (genvar i = 0; i < MAX_COLUMN_LINES; i++) begin : g_lane
    logic signed [HALF_W-1:0] slope;
    logic signed [HALF_W-1:0] icpt;
    logic signed [PROD_W-1:0] prod;
    logic signed [XD_W-1:0]   xd;
    logic signed [CMP_W-1:0]  lhs;
    logic signed [CMP_W-1:0]  rhs;

    assign slope = lines[i][phid_pkg::LINE_W-1:HALF_W];
    assign icpt  = lines[i][HALF_W-1:0];

    // Stage 1: the product and the horizontal offset to the intercept.
    always_ff @(posedge clk) begin
      prod <= PROD_W'(slope) * PROD_W'(y);
      xd   <= XD_W'(x) - XD_W'(icpt);
    end

    assign lhs = CMP_W'(prod);
    assign rhs = CMP_W'(xd) <<< FRAC_W;

    // Stage 2: the line counts only if it is in use.
    always_ff @(posedge clk) begin
      right[i] <= (lhs > rhs) && (phid_pkg::LINE_CNT_W'(i) < lines_eff);
    end
  end

  always_comb begin
    col_next = phid_pkg::COL_W'(lines_eff);
    for (int i = MAX_COLUMN_LINES - 1; i >= 0; i--) begin
      if (right[i]) begin
        col_next = phid_pkg::COL_W'(i);
      end
    end
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    col <= col_next;
  end

endmodule

>>> rtl/pad_hit_position_to_id.sv
// Pad hit position to pad number for a trapezoidal pad board. A hit (hit_x,
// hit_y) in signed 1/256 mm units is taken whenever start is high and busy is
// low, one item per clock with no gaps, and its result is registered onto the
// ports with done high for a single cycle. The result cannot be held off, so
// the receiver must take every item in the cycle it is shown. The row lookup
// is the longer path; it divides the offset into the inner rows by the row
// height one quotient bit per pipeline stage. busy is high only during reset
// and the cycle after it; afterwards the block always takes items.
// Configuration writes are taken whenever cfg_ready is high but must only be
// made while no items are in flight, since the pipeline reads the registers
// live.
`include "pad_hit_position_to_id_macros.svh"

module pad_hit_position_to_id #(
  parameter int MAX_COLUMN_LINES = phid_pkg::MAX_COLUMN_LINES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [phid_pkg::POS_W-1:0]    hit_x,
  input  logic signed [phid_pkg::POS_W-1:0]    hit_y,
  output logic                                 done,
  output logic [phid_pkg::PAD_W-1:0]           pad_number,
  output logic [phid_pkg::ROW_W-1:0]           pad_row,
  output logic [phid_pkg::COL_W-1:0]           pad_column,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [phid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [phid_pkg::LINE_W-1:0]          cfg_data
);

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int PIPE_LAT = phid_pkg::ROW_LAT + 2;
  localparam int COL_DLY = phid_pkg::ROW_LAT - phid_pkg::COL_LAT;

  // Configuration registers.
  logic                                  in_reset;
  phid_pkg::row_cfg_t                    row_cfg;
  logic [phid_pkg::LINE_CNT_W-1:0]       line_count;
  logic [MAX_COLUMN_LINES-1:0][phid_pkg::LINE_W-1:0] column_line;

  // Pipeline.
  logic                                  valid0;
  logic signed [phid_pkg::POS_W-1:0]     x0;
  logic signed [phid_pkg::POS_W-1:0]     y0;
  logic [phid_pkg::ROW_LAT:1]            valid_pipe;
  logic [phid_pkg::ROW_W-1:0]            row_res;
  logic [phid_pkg::COL_W-1:0]            col_res;
  logic [phid_pkg::COL_W-1:0]            col_dly [0:COL_DLY-1];
  logic [phid_pkg::LINE_CNT_W-1:0]       lines_eff;
  logic [phid_pkg::LINE_CNT_W:0]         cols;
  logic                                  accept;

  // Nothing is taken at an edge where reset is high, so an item or a register
  // write offered then is never counted as accepted.
  assign busy      = rst || in_reset;
  assign cfg_ready = !(rst || in_reset);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    in_reset <= rst;
  end

  // Register writes. The boundary lines that are not built are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cfg.first_end  <= '0;
      row_cfg.last_begin <= '0;
      row_cfg.height     <= phid_pkg::HEIGHT_W'(1);
      row_cfg.count      <= phid_pkg::COUNT_W'(1);
      line_count         <= '0;
      column_line        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        phid_pkg::REG_ROW_FIRST_END: begin
          row_cfg.first_end <= cfg_data[phid_pkg::POS_W-1:0];
        end
        phid_pkg::REG_ROW_LAST_BEGIN: begin
          row_cfg.last_begin <= cfg_data[phid_pkg::POS_W-1:0];
        end
        phid_pkg::REG_ROW_HEIGHT: begin
          row_cfg.height <= cfg_data[phid_pkg::HEIGHT_W-1:0];
        end
        phid_pkg::REG_ROW_COUNT: begin
          row_cfg.count <= cfg_data[phid_pkg::COUNT_W-1:0];
        end
        phid_pkg::REG_LINE_COUNT: begin
          line_count <= cfg_data[phid_pkg::LINE_CNT_W-1:0];
        end
        default: begin
          for (int i = 0; i < MAX_COLUMN_LINES; i++) begin
            if (cfg_index == phid_pkg::CFG_IDX_W'(phid_pkg::REG_COLUMN_LINE_BASE + i)) begin
              column_line[i] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  // Lines in use never exceed the number built; columns are one more.
  always_comb begin
    if (line_count > phid_pkg::LINE_CNT_W'(MAX_COLUMN_LINES)) begin
      lines_eff = phid_pkg::LINE_CNT_W'(MAX_COLUMN_LINES);
    end else begin
      lines_eff = line_count;
    end
    cols = (phid_pkg::LINE_CNT_W + 1)'(lines_eff) + (phid_pkg::LINE_CNT_W + 1)'(1);
  end

  // Input register. The valid bit travels alongside the data through every
  // stage, so outside reset a new item can enter on each clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0     <= 1'b0;
      valid_pipe <= '0;
    end else begin
      valid0     <= accept;
      valid_pipe <= {valid_pipe[phid_pkg::ROW_LAT-1:1], valid0};
    end
  end

  always_ff @(posedge clk) begin
    x0 <= hit_x;
    y0 <= hit_y;
  end

  phid_row_unit u_row (
    .clk (clk),
    .y   (y0),
    .cfg (row_cfg),
    .row (row_res)
  );

  phid_col_unit #(
    .MAX_COLUMN_LINES (MAX_COLUMN_LINES)
  ) u_col (
    .clk       (clk),
    .x         (x0),
    .y         (y0),
    .lines     (column_line),
    .lines_eff (lines_eff),
    .col       (col_res)
  );

  // The column is ready well before the row; it waits in a short delay line.
  always_ff @(posedge clk) begin
    col_dly[0] <= col_res;
    for (int i = 1; i < COL_DLY; i++) begin
      col_dly[i] <= col_dly[i-1];
    end
  end

  // Output register: the pad number is row * columns + column + 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_pipe[phid_pkg::ROW_LAT];
    end
  end

  always_ff @(posedge clk) begin
    pad_row    <= row_res;
    pad_column <= col_dly[COL_DLY-1];
    pad_number <= phid_pkg::PAD_W'(row_res) * phid_pkg::PAD_W'(cols) +
                  phid_pkg::PAD_W'(col_dly[COL_DLY-1]) + phid_pkg::PAD_W'(1);
  end

  // A result appears only for an item that was taken into the pipeline.
  `PHID_ASSERT_SAME(a_done_follows_accept, done, $past(accept, PIPE_LAT), "result without an item")
  // Every taken item yields a result.
  `PHID_ASSERT_SAME(a_accept_gives_done, $past(accept, PIPE_LAT), done, "item lost in pipeline")
  // The column never exceeds the number of lines in use.
  `PHID_ASSERT_SAME(a_column_in_range, done, pad_column <= lines_eff, "column out of range")
  // Once out of reset the block never turns busy again.
  `PHID_ASSERT_NEXT(a_busy_stays_low, !busy, !busy, "busy raised outside reset")

endmodule
